@@ rtl/mfs_pkg.sv @@
// Shared definitions for the maximum-frequency stack.
// Holds parameter defaults, request and status codes and the free-list command type.
// No dependencies.
package mfs_pkg;

    // Parameter defaults
    localparam int DEF_CAPACITY   = 256;
    localparam int DEF_VALUE_BITS = 12;

    // Request kind carried on s_tuser
    localparam logic REQ_PUSH = 1'b0;
    localparam logic REQ_POP  = 1'b1;

    // Result status carried on m_tuser
    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2
    } status_t;

    // Free-list command: take a slot, or give one back
    typedef struct packed {
        logic take;
        logic give;
    } fl_cmd_t;

endpackage

@@ rtl/mfs_count_mem.sv @@
// Per-value occurrence counter memory with a clearing sweep after reset.
// One read port with registered data, one write port.
// Depends on mfs_pkg (defaults only).
module mfs_count_mem #(
    parameter int VALUE_BITS = mfs_pkg::DEF_VALUE_BITS,
    parameter int LEVEL_BITS = $clog2(mfs_pkg::DEF_CAPACITY + 1)
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  rd_en,
    input  logic [VALUE_BITS-1:0] rd_addr,
    output logic [LEVEL_BITS-1:0] rd_data,
    input  logic                  wr_en,
    input  logic [VALUE_BITS-1:0] wr_addr,
    input  logic [LEVEL_BITS-1:0] wr_data,
    output logic                  clear_busy
);

    localparam longint DEPTH = 64'd1 << VALUE_BITS;

    logic [LEVEL_BITS-1:0] mem [DEPTH];
    logic [LEVEL_BITS-1:0] rd_data_reg;
    logic                  clearing_reg;
    logic [VALUE_BITS-1:0] clr_addr_reg;

    // Sweep every entry to zero once after reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clearing_reg <= 1'b1;
            clr_addr_reg <= '0;
        end else if (clearing_reg) begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
            if (clr_addr_reg == '1) begin
                clearing_reg <= 1'b0;
            end
        end
    end

    // Write port is shared with the sweep
    always_ff @(posedge aclk) begin
        if (clearing_reg) begin
            mem[clr_addr_reg] <= '0;
        end else if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data    = rd_data_reg;
    assign clear_busy = clearing_reg;

endmodule

@@ rtl/mfs_free_list.sv @@
// Free-slot stack held in a memory with a fill mark.
// Entries below the lowest index ever taken read as their own index.
// Depends on mfs_pkg for fl_cmd_t.
module mfs_free_list #(
    parameter int CAPACITY = mfs_pkg::DEF_CAPACITY,
    parameter int SLOT_BITS = $clog2(mfs_pkg::DEF_CAPACITY)
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  mfs_pkg::fl_cmd_t     cmd,
    input  logic [SLOT_BITS-1:0] give_slot,
    output logic [SLOT_BITS-1:0] take_slot,
    output logic                 empty
);

    localparam int CNT_BITS = $clog2(CAPACITY + 1);

    logic [SLOT_BITS-1:0] mem [CAPACITY];
    logic [CNT_BITS-1:0]  fc_reg;
    logic [CNT_BITS-1:0]  lo_reg;
    logic [CNT_BITS-1:0]  fc_dec;
    logic                 take_hit;
    logic                 hit_reg;
    logic [SLOT_BITS-1:0] idx_reg;
    logic [SLOT_BITS-1:0] rd_reg;
    logic                 can_give;

    assign fc_dec   = fc_reg - 1'b1;
    assign take_hit = (fc_dec >= lo_reg);
    assign can_give = (fc_reg < CNT_BITS'(CAPACITY));

    // Hold the count and the lowest index reached so far
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fc_reg <= CNT_BITS'(CAPACITY);
            lo_reg <= CNT_BITS'(CAPACITY);
        end else if (cmd.take) begin
            fc_reg <= fc_dec;
            if (!take_hit) begin
                lo_reg <= fc_dec;
            end
        end else if (cmd.give && can_give) begin
            fc_reg <= fc_reg + 1'b1;
        end
    end

    // Memory access; a miss below the mark yields the index itself
    always_ff @(posedge aclk) begin
        if (cmd.give && can_give) begin
            mem[fc_reg[SLOT_BITS-1:0]] <= give_slot;
        end
        if (cmd.take) begin
            rd_reg  <= mem[fc_dec[SLOT_BITS-1:0]];
            idx_reg <= fc_dec[SLOT_BITS-1:0];
            hit_reg <= take_hit;
        end
    end

    assign take_slot = hit_reg ? rd_reg : idx_reg;
    assign empty     = (fc_reg == '0);

endmodule

@@ rtl/mfs_link_mem.sv @@
// Level-top and slot-entry memories of the frequency stack.
// Slot entries pack {value, slot below, bottom flag}; reads are registered.
// Depends on mfs_pkg (defaults only).
module mfs_link_mem #(
    parameter int CAPACITY   = mfs_pkg::DEF_CAPACITY,
    parameter int SLOT_BITS  = $clog2(mfs_pkg::DEF_CAPACITY),
    parameter int ENTRY_BITS = mfs_pkg::DEF_VALUE_BITS + $clog2(mfs_pkg::DEF_CAPACITY) + 1
) (
    input  logic                  aclk,
    input  logic                  lt_rd_en,
    input  logic [SLOT_BITS-1:0]  lt_rd_idx,
    output logic [SLOT_BITS-1:0]  lt_rd_data,
    input  logic                  lt_wr_en,
    input  logic [SLOT_BITS-1:0]  lt_wr_idx,
    input  logic [SLOT_BITS-1:0]  lt_wr_data,
    input  logic                  sl_rd_en,
    input  logic [SLOT_BITS-1:0]  sl_rd_idx,
    output logic [ENTRY_BITS-1:0] sl_rd_data,
    input  logic                  sl_wr_en,
    input  logic [SLOT_BITS-1:0]  sl_wr_idx,
    input  logic [ENTRY_BITS-1:0] sl_wr_data
);

    logic [SLOT_BITS-1:0]  lt_mem [CAPACITY];
    logic [ENTRY_BITS-1:0] sl_mem [CAPACITY];
    logic [SLOT_BITS-1:0]  lt_rd_reg;
    logic [ENTRY_BITS-1:0] sl_rd_reg;

    // Top slot of each level, indexed by level minus one
    always_ff @(posedge aclk) begin
        if (lt_wr_en) begin
            lt_mem[lt_wr_idx] <= lt_wr_data;
        end
        if (lt_rd_en) begin
            lt_rd_reg <= lt_mem[lt_rd_idx];
        end
    end

    // Slot entries
    always_ff @(posedge aclk) begin
        if (sl_wr_en) begin
            sl_mem[sl_wr_idx] <= sl_wr_data;
        end
        if (sl_rd_en) begin
            sl_rd_reg <= sl_mem[sl_rd_idx];
        end
    end

    assign lt_rd_data = lt_rd_reg;
    assign sl_rd_data = sl_rd_reg;

endmodule

@@ rtl/max_frequency_stack.sv @@
// Maximum-frequency stack: one item at a time, state kept in synchronous memories.
// Push steps: count read, level-top read, write-back.
// Pop steps: level-top read, slot read, count read, write-back; errors are answered from idle.
// The next item is taken in idle once the output register is free or being read out.
// Reset is synchronous, active low; afterwards all 2^VALUE_BITS entries (4096 by default)
// of the count memory are swept to zero, and s_tready stays low until idle is entered.
module max_frequency_stack #(
    parameter int CAPACITY   = mfs_pkg::DEF_CAPACITY,
    parameter int VALUE_BITS = mfs_pkg::DEF_VALUE_BITS,
    localparam int LEVEL_BITS = $clog2(CAPACITY + 1),
    localparam int S_DATA_W   = ((VALUE_BITS + 7) / 8) * 8,
    localparam int M_DATA_W   = ((VALUE_BITS + LEVEL_BITS + 7) / 8) * 8
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // push_value
    input  logic [0:0]          s_tuser,   // req_type
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,   // out_value, level
    output logic [1:0]          m_tuser    // status
);

    localparam int SLOT_BITS  = $clog2(CAPACITY);
    localparam int ENTRY_BITS = VALUE_BITS + SLOT_BITS + 1;

    typedef enum logic [6:0] {
        ST_CLEAR       = 7'b0000001,
        ST_IDLE        = 7'b0000010,
        ST_PUSH_LINK   = 7'b0000100,
        ST_PUSH_COMMIT = 7'b0001000,
        ST_POP_SLOT    = 7'b0010000,
        ST_POP_COUNT   = 7'b0100000,
        ST_POP_COMMIT  = 7'b1000000
    } state_t;

    state_t                state_reg, state_next;
    logic [VALUE_BITS-1:0] v_reg, v_next;
    logic [LEVEL_BITS-1:0] c_reg, c_next;
    logic [SLOT_BITS-1:0]  slot_reg, slot_next;
    logic [LEVEL_BITS-1:0] top_level_reg, top_level_next;

    logic                  m_tvalid_reg;
    logic [VALUE_BITS-1:0] out_value_reg, out_value_next;
    logic [LEVEL_BITS-1:0] level_reg, level_next;
    mfs_pkg::status_t      status_reg, status_next;
    logic                  out_load;

    logic                  s_acc;
    logic [VALUE_BITS-1:0] in_value;

    logic                  cnt_rd_en, cnt_wr_en, clear_busy;
    logic [VALUE_BITS-1:0] cnt_rd_addr, cnt_wr_addr;
    logic [LEVEL_BITS-1:0] cnt_rd_data, cnt_wr_data;

    mfs_pkg::fl_cmd_t      fl_cmd;
    logic [SLOT_BITS-1:0]  fl_slot;
    logic                  fl_empty;

    logic                  lt_rd_en, lt_wr_en, sl_rd_en, sl_wr_en;
    logic [SLOT_BITS-1:0]  lt_rd_idx, lt_rd_data, lt_wr_idx, lt_wr_data;
    logic [SLOT_BITS-1:0]  sl_rd_idx, sl_wr_idx;
    logic [ENTRY_BITS-1:0] sl_rd_data, sl_wr_data;

    logic [VALUE_BITS-1:0] sl_value;
    logic [SLOT_BITS-1:0]  sl_below;
    logic                  sl_bottom;
    logic                  push_bottom;

    assign s_tready = (state_reg == ST_IDLE) && (!m_tvalid_reg || m_tready);
    assign s_acc    = s_tvalid && s_tready;
    assign in_value = s_tdata[VALUE_BITS-1:0];

    assign {sl_value, sl_below, sl_bottom} = sl_rd_data;
    assign push_bottom = (c_reg > top_level_reg);

    // Sequencer: issue reads, then modify and write back
    always_comb begin
        state_next     = state_reg;
        v_next         = v_reg;
        c_next         = c_reg;
        slot_next      = slot_reg;
        top_level_next = top_level_reg;
        out_load       = 1'b0;
        out_value_next = v_reg;
        level_next     = c_reg;
        status_next    = mfs_pkg::STAT_OK;
        cnt_rd_en      = 1'b0;
        cnt_rd_addr    = v_reg;
        cnt_wr_en      = 1'b0;
        cnt_wr_addr    = v_reg;
        cnt_wr_data    = c_reg;
        fl_cmd         = '0;
        lt_rd_en       = 1'b0;
        lt_rd_idx      = SLOT_BITS'(top_level_reg - 1'b1);
        lt_wr_en       = 1'b0;
        lt_wr_idx      = SLOT_BITS'(c_reg - 1'b1);
        lt_wr_data     = slot_reg;
        sl_rd_en       = 1'b0;
        sl_rd_idx      = lt_rd_data;
        sl_wr_en       = 1'b0;
        sl_wr_idx      = slot_reg;
        sl_wr_data     = {v_reg, (push_bottom ? '0 : lt_rd_data), push_bottom};

        unique case (state_reg)
            ST_CLEAR: begin
                if (!clear_busy) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_acc) begin
                    if (s_tuser[0] == mfs_pkg::REQ_PUSH) begin
                        if (fl_empty) begin
                            out_load       = 1'b1;
                            out_value_next = '0;
                            level_next     = '0;
                            status_next    = mfs_pkg::STAT_FULL;
                        end else begin
                            cnt_rd_en   = 1'b1;
                            cnt_rd_addr = in_value;
                            fl_cmd.take = 1'b1;
                            v_next      = in_value;
                            state_next  = ST_PUSH_LINK;
                        end
                    end else begin
                        if (top_level_reg == '0) begin
                            out_load       = 1'b1;
                            out_value_next = '0;
                            level_next     = '0;
                            status_next    = mfs_pkg::STAT_EMPTY;
                        end else begin
                            lt_rd_en   = 1'b1;
                            c_next     = top_level_reg;
                            state_next = ST_POP_SLOT;
                        end
                    end
                end
            end
            ST_PUSH_LINK: begin
                c_next     = cnt_rd_data + 1'b1;
                slot_next  = fl_slot;
                lt_rd_en   = 1'b1;
                lt_rd_idx  = SLOT_BITS'(cnt_rd_data);
                state_next = ST_PUSH_COMMIT;
            end
            ST_PUSH_COMMIT: begin
                sl_wr_en  = 1'b1;
                lt_wr_en  = 1'b1;
                cnt_wr_en = 1'b1;
                if (push_bottom) begin
                    top_level_next = c_reg;
                end
                out_load   = 1'b1;
                state_next = ST_IDLE;
            end
            ST_POP_SLOT: begin
                slot_next  = lt_rd_data;
                sl_rd_en   = 1'b1;
                state_next = ST_POP_COUNT;
            end
            ST_POP_COUNT: begin
                v_next      = sl_value;
                cnt_rd_en   = 1'b1;
                cnt_rd_addr = sl_value;
                state_next  = ST_POP_COMMIT;
            end
            ST_POP_COMMIT: begin
                cnt_wr_en   = 1'b1;
                cnt_wr_data = cnt_rd_data - LEVEL_BITS'(cnt_rd_data != '0);
                if (sl_bottom) begin
                    top_level_next = c_reg - 1'b1;
                end else begin
                    lt_wr_en   = 1'b1;
                    lt_wr_data = sl_below;
                end
                fl_cmd.give = 1'b1;
                out_load    = 1'b1;
                state_next  = ST_IDLE;
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            top_level_reg <= '0;
        end else begin
            state_reg     <= state_next;
            top_level_reg <= top_level_next;
        end
    end

    // Working registers of the item in flight
    always_ff @(posedge aclk) begin
        v_reg    <= v_next;
        c_reg    <= c_next;
        slot_reg <= slot_next;
    end

    // Output register: load a result, drop it after the transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_value_reg <= out_value_next;
            level_reg     <= level_next;
            status_reg    <= status_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = M_DATA_W'({level_reg, out_value_reg});
    assign m_tuser  = status_reg;

    mfs_count_mem #(
        .VALUE_BITS (VALUE_BITS),
        .LEVEL_BITS (LEVEL_BITS)
    ) u_count_mem (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .rd_en      (cnt_rd_en),
        .rd_addr    (cnt_rd_addr),
        .rd_data    (cnt_rd_data),
        .wr_en      (cnt_wr_en),
        .wr_addr    (cnt_wr_addr),
        .wr_data    (cnt_wr_data),
        .clear_busy (clear_busy)
    );

    mfs_free_list #(
        .CAPACITY  (CAPACITY),
        .SLOT_BITS (SLOT_BITS)
    ) u_free_list (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (fl_cmd),
        .give_slot (slot_reg),
        .take_slot (fl_slot),
        .empty     (fl_empty)
    );

    mfs_link_mem #(
        .CAPACITY   (CAPACITY),
        .SLOT_BITS  (SLOT_BITS),
        .ENTRY_BITS (ENTRY_BITS)
    ) u_link_mem (
        .aclk       (aclk),
        .lt_rd_en   (lt_rd_en),
        .lt_rd_idx  (lt_rd_idx),
        .lt_rd_data (lt_rd_data),
        .lt_wr_en   (lt_wr_en),
        .lt_wr_idx  (lt_wr_idx),
        .lt_wr_data (lt_wr_data),
        .sl_rd_en   (sl_rd_en),
        .sl_rd_idx  (sl_rd_idx),
        .sl_rd_data (sl_rd_data),
        .sl_wr_en   (sl_wr_en),
        .sl_wr_idx  (sl_wr_idx),
        .sl_wr_data (sl_wr_data)
    );

endmodule

@@ rtl/mfs_checker.sv @@
// Port-level checks for the maximum-frequency stack, bound to the top level.
// Depends on mfs_pkg for status codes and on max_frequency_stack for the bind.
module mfs_checker #(
    parameter int CAPACITY   = mfs_pkg::DEF_CAPACITY,
    parameter int VALUE_BITS = mfs_pkg::DEF_VALUE_BITS,
    localparam int LEVEL_BITS = $clog2(CAPACITY + 1),
    localparam int S_DATA_W   = ((VALUE_BITS + 7) / 8) * 8,
    localparam int M_DATA_W   = ((VALUE_BITS + LEVEL_BITS + 7) / 8) * 8
) (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_tvalid,
    input logic                s_tready,
    input logic [S_DATA_W-1:0] s_tdata,   // push_value
    input logic [0:0]          s_tuser,   // req_type
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [M_DATA_W-1:0] m_tdata,   // out_value, level
    input logic [1:0]          m_tuser    // status
);

    // A waiting request keeps its payload until the transfer
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata) && $stable(s_tuser))
        else $error("request changed while waiting");

    // A stalled result keeps its payload
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // A result leaves only through a transfer
    a_out_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(m_tvalid) |-> $past(m_tready))
        else $error("result dropped without transfer");

    // Refused requests carry a zero value and level
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == mfs_pkg::STAT_FULL || m_tuser == mfs_pkg::STAT_EMPTY)
        |-> m_tdata == '0)
        else $error("error result with non-zero payload");

    // A performed push or pop always reports a level of at least one
    a_ok_level: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == mfs_pkg::STAT_OK
        |-> m_tdata[VALUE_BITS +: LEVEL_BITS] != '0)
        else $error("successful result with zero level");

endmodule

bind max_frequency_stack mfs_checker #(
    .CAPACITY   (CAPACITY),
    .VALUE_BITS (VALUE_BITS)
) u_mfs_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

@@ tb/sv/tb_max_frequency_stack.sv @@
`timescale 1ns / 100ps
// Self-checking bench for max_frequency_stack: directed and random push/pop traffic,
// a behavioural frequency-stack model and an in-order scoreboard on the result stream.
// Depends on rtl/mfs_pkg.sv and rtl/max_frequency_stack.sv.
module tb_max_frequency_stack;
    import mfs_pkg::*;

    localparam int CAP          = DEF_CAPACITY;
    localparam int NVAL         = 1 << DEF_VALUE_BITS;
    localparam int ITEM_TARGET  = 1650;
    localparam int IDLE_LIMIT   = 20000;
    localparam int DRAIN_CYCLES = 20;

    typedef struct {
        logic        kind;
        logic [11:0] value;
        int unsigned idle_after;
    } stack_req_t;

    typedef struct {
        logic [11:0] value;
        logic [8:0]  lvl;
        status_t     status;
    } stack_res_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;   // push_value
    logic [0:0]  s_tuser  = '0;   // req_type
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;         // out_value, level
    logic [1:0]  m_tuser;         // status

    // Model state: per-value counts, per-level stacks threaded through slots
    logic [8:0]  freq_of    [NVAL];
    logic [7:0]  level_head [CAP];
    logic [11:0] slot_val   [CAP];
    logic [7:0]  slot_next  [CAP];
    bit          slot_floor [CAP];
    logic [7:0]  free_stack [CAP];
    int          free_n;
    int          high_level;

    stack_res_t  awaited_results[$];
    stack_req_t  request_q[$];
    int          held;            // entries the stimulus expects the stack to hold
    int          mismatches = 0;

    max_frequency_stack u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Apply one accepted request to the model and queue the result it must produce
    function automatic void apply_stack_request(logic kind, logic [11:0] v);
        stack_res_t res;
        int         slot;
        int         c;
        res = '{value: 12'd0, lvl: 9'd0, status: STAT_OK};
        if (kind == REQ_PUSH) begin
            if (free_n == 0) begin
                res.status = STAT_FULL;
            end else begin
                free_n--;
                slot = free_stack[free_n];
                c = freq_of[v] + 1;
                freq_of[v] = 9'(c);
                slot_val[slot] = v;
                // a new highest level starts with this slot at its bottom
                if (c > high_level) begin
                    slot_floor[slot] = 1'b1;
                    high_level = c;
                end else begin
                    slot_floor[slot] = 1'b0;
                    slot_next[slot] = level_head[c-1];
                end
                level_head[c-1] = 8'(slot);
                res.value = v;
                res.lvl = 9'(c);
            end
        end else if (high_level == 0) begin
            res.status = STAT_EMPTY;
        end else begin
            slot = level_head[high_level-1];
            res.value = slot_val[slot];
            res.lvl = 9'(high_level);
            freq_of[res.value] = freq_of[res.value] - 9'd1;
            // drop the level once its bottom entry leaves
            if (slot_floor[slot])
                high_level--;
            else
                level_head[high_level-1] = slot_next[slot];
            free_stack[free_n] = 8'(slot);
            free_n++;
        end
        awaited_results.push_back(res);
    endfunction

    // Idle length: mostly none or short, a few long
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic void queue_request(logic kind, logic [11:0] v, bit calm);
        stack_req_t item;
        item.kind = kind;
        item.value = v;
        item.idle_after = calm ? 0 : pick_gap();
        request_q.push_back(item);
        if (kind == REQ_PUSH && held < CAP)
            held++;
        else if (kind == REQ_POP && held > 0)
            held--;
    endfunction

    initial begin : stimulus
        logic [11:0] pool [8];
        int          pool_n;
        int          fills;
        int          mode;
        bit          calm;

        // Model reset state
        foreach (freq_of[k]) freq_of[k] = '0;
        foreach (level_head[k]) begin
            level_head[k] = '0;
            slot_val[k]   = '0;
            slot_next[k]  = '0;
            slot_floor[k] = 1'b0;
            free_stack[k] = 8'(k);
        end
        free_n = CAP;
        high_level = 0;
        held = 0;
        fills = 0;

        // Directed: pop with nothing stored, extreme values, ties on a level, drain past empty
        queue_request(REQ_POP,  12'hFFF, 1'b0);
        queue_request(REQ_PUSH, 12'h000, 1'b0);
        queue_request(REQ_PUSH, 12'hFFF, 1'b0);
        queue_request(REQ_PUSH, 12'h000, 1'b0);
        queue_request(REQ_PUSH, 12'hAAA, 1'b0);
        queue_request(REQ_PUSH, 12'h555, 1'b0);
        queue_request(REQ_PUSH, 12'hFFF, 1'b0);
        queue_request(REQ_PUSH, 12'hFFF, 1'b0);
        repeat (7) queue_request(REQ_POP, 12'($urandom()), 1'b0);
        queue_request(REQ_POP, 12'h000, 1'b0);
        queue_request(REQ_POP, 12'hFFF, 1'b0);

        // Random phases
        while (request_q.size() < ITEM_TARGET) begin
            calm = ($urandom_range(0, 3) == 0);
            mode = $urandom_range(0, 9);
            if (fills < 2 && (mode >= 8 || (fills == 0 && request_q.size() > 900))) begin
                // empty, fill to capacity, push beyond it, then drain past empty;
                // the first time a single value climbs to the top level
                pool_n = (fills == 0) ? 1 : $urandom_range(2, 6);
                for (int i = 0; i < pool_n; i++) pool[i] = 12'($urandom_range(0, NVAL - 1));
                while (held > 0) queue_request(REQ_POP, 12'($urandom()), calm);
                while (held < CAP)
                    queue_request(REQ_PUSH, pool[$urandom_range(0, pool_n - 1)], calm);
                repeat ($urandom_range(1, 3)) queue_request(REQ_PUSH, 12'($urandom()), calm);
                while (held > 0) queue_request(REQ_POP, 12'($urandom()), calm);
                repeat ($urandom_range(1, 2)) queue_request(REQ_POP, 12'($urandom()), calm);
                fills++;
            end else if (mode < 6) begin
                // push-leaning mix over a small value set so that counts build up
                pool_n = $urandom_range(1, 8);
                for (int i = 0; i < pool_n; i++) pool[i] = 12'($urandom_range(0, NVAL - 1));
                repeat ($urandom_range(20, 80)) begin
                    if ($urandom_range(0, 99) < 8)
                        queue_request($urandom_range(0, 1) ? REQ_POP : REQ_PUSH,
                                      12'($urandom()), calm);
                    else if ($urandom_range(0, 99) < 62)
                        queue_request(REQ_PUSH, pool[$urandom_range(0, pool_n - 1)], calm);
                    else
                        queue_request(REQ_POP, 12'($urandom()), calm);
                end
            end else begin
                // unstructured noise
                repeat ($urandom_range(10, 30))
                    queue_request($urandom_range(0, 1) ? REQ_POP : REQ_PUSH,
                                  12'($urandom()), calm);
            end
        end

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // Wait for every request to be taken and every result to be seen
        while (request_q.size() != 0 || s_tvalid || awaited_results.size() != 0)
            @(negedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0 && awaited_results.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // Request driver
    int unsigned send_idle;
    stack_req_t  next_req;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            send_idle <= 0;
        end else if (!s_tvalid || s_tready) begin
            // a transfer completing here advances the model
            if (s_tvalid)
                apply_stack_request(s_tuser[0], s_tdata[11:0]);
            if (send_idle != 0) begin
                send_idle <= send_idle - 1;
                s_tvalid <= 1'b0;
            end else if (request_q.size() != 0) begin
                next_req = request_q.pop_front();
                s_tvalid <= 1'b1;
                s_tuser <= next_req.kind;
                s_tdata <= {4'h0, next_req.value};
                send_idle <= next_req.idle_after;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Result monitor and receiver back-pressure
    int unsigned rx_stall;
    int unsigned rx_calm;
    stack_res_t  want;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_stall <= 0;
            rx_calm <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (awaited_results.size() == 0) begin
                    $error("result with no request outstanding: out_value %0d level %0d status %0d",
                           m_tdata[11:0], m_tdata[20:12], m_tuser);
                    mismatches++;
                end else begin
                    want = awaited_results.pop_front();
                    if (m_tdata[11:0] !== want.value) begin
                        $error("out_value: expected %0d, got %0d", want.value, m_tdata[11:0]);
                        mismatches++;
                    end
                    if (m_tdata[20:12] !== want.lvl) begin
                        $error("level: expected %0d, got %0d", want.lvl, m_tdata[20:12]);
                        mismatches++;
                    end
                    if (m_tuser !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, m_tuser);
                        mismatches++;
                    end
                end
            end
            // hold ready through calm stretches, otherwise drop it for random spells
            if (rx_calm != 0) begin
                rx_calm <= rx_calm - 1;
                m_tready <= 1'b1;
            end else if (rx_stall != 0) begin
                rx_stall <= rx_stall - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if ($urandom_range(0, 99) < 3)
                    rx_calm <= $urandom_range(50, 300);
                else if ($urandom_range(0, 99) < 40)
                    rx_stall <= pick_gap();
            end
        end
    end

    // Watchdog: stop when no transfer happens on either side for too long
    int unsigned idle_cycles = 0;

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

endmodule
